/* design/firp16_pkg.sv */
// Shared widths and constants for the PCM16 FIR.
// No dependencies; every other design file imports this package.
package firp16_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 16;
    localparam int FRAC_BITS    = 15;
    localparam int NUM_COEF     = 8;
    localparam int TAPS_DEFAULT = 8;
    localparam int CFG_IDX_W    = $clog2(NUM_COEF);

endpackage

/* design/fir_filter_pcm16_unit.sv */
// Top level of the PCM16 FIR filter: coefficient registers, the tap cell chain,
// the adder tree and the output stage.
// Depends on firp16_pkg, firp16_tap_cell, firp16_out_stage.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  s_axis   | in        | tdata[15:0] sample_in, tuser[0] restart
//  m_axis   | out       | tdata[15:0] sample_out, tuser[0] clipped
//  cfg      | in        | cfg_addr selects coefficient_0..7, cfg_wdata Q1.15
//
// One sample per clock is sustained while m_tready allows; a result passes the cell
// product registers, adder tree and sum register, then the truncate/saturate register.
// Direct form: each cell holds one history sample and hands it to its neighbour on
// every input transaction, so new coefficients act on the stored history at once.
// Reset (aresetn low, synchronous) zeroes the coefficients and the history.
// With m_tready low the output holds; two more samples can still be taken into the
// product and sum registers, after which s_tready drops until the result drains.
module fir_filter_pcm16_unit #(
    parameter int TAPS = firp16_pkg::TAPS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,  // [15:0] sample_in
    input  logic [0:0]                          s_tuser,  // [0] restart

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,  // [15:0] sample_out
    output logic [0:0]                          m_tuser,  // [0] clipped

    input  logic                                cfg_we,
    input  logic [firp16_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [firp16_pkg::COEF_W-1:0]       cfg_wdata
);
    import firp16_pkg::*;

    // exact sum of TAPS products of magnitude up to 2^30
    localparam int ACC_W  = SAMPLE_W + COEF_W + $clog2(TAPS) + 1;
    localparam int PROD_W = SAMPLE_W + COEF_W;

    logic signed [COEF_W-1:0]   coef_reg [NUM_COEF];
    logic signed [SAMPLE_W-1:0] tap_src [TAPS];
    logic signed [SAMPLE_W-1:0] held [TAPS];
    logic [TAPS-1:0]            tap_clr;
    logic signed [PROD_W-1:0]   prod [NUM_COEF];
    logic signed [ACC_W-1:0]    pair_sum [NUM_COEF/2];
    logic signed [ACC_W-1:0]    quad_sum [NUM_COEF/4];
    logic signed [ACC_W-1:0]    sum_next;
    logic signed [ACC_W-1:0]    sum_reg;
    logic                       prod_valid_reg;
    logic                       sum_valid_reg;
    logic                       advance;
    logic                       sum_load;
    logic                       take;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       out_clipped;

    // coefficient registers; all eight are stored, only the first TAPS are used
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            coef_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // output register moves when empty or being drained
    assign advance  = !m_tvalid || m_tready;
    // sum register loads when it moves on or holds nothing
    assign sum_load = advance || !sum_valid_reg;
    // product registers are free when they move on or hold nothing
    assign s_tready = sum_load || !prod_valid_reg;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                prod_valid_reg <= take;
            end
            if (sum_load) begin
                sum_valid_reg <= prod_valid_reg;
            end
        end
    end

    // cell 0 takes the new sample; later cells take the neighbour's held sample,
    // cleared on restart
    for (genvar k = 0; k < TAPS; k++) begin : g_tap
        if (k == 0) begin : g_head
            assign tap_src[k] = s_tdata;
            assign tap_clr[k] = 1'b0;
        end else begin : g_body
            assign tap_src[k] = held[k-1];
            assign tap_clr[k] = s_tuser[0];
        end

        firp16_tap_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .load     (take),
            .clear    (tap_clr[k]),
            .tap_in   (tap_src[k]),
            .coef     (coef_reg[k]),
            .tap_out  (held[k]),
            .prod_out (prod[k])
        );
    end

    // taps beyond TAPS contribute nothing
    for (genvar k = TAPS; k < NUM_COEF; k++) begin : g_unused
        assign prod[k] = '0;
    end

    // three-level adder tree over the registered products
    always_comb begin
        for (int i = 0; i < NUM_COEF/2; i++) begin
            pair_sum[i] = ACC_W'(prod[2*i]) + ACC_W'(prod[2*i+1]);
        end
        for (int i = 0; i < NUM_COEF/4; i++) begin
            quad_sum[i] = pair_sum[2*i] + pair_sum[2*i+1];
        end
        sum_next = quad_sum[0] + quad_sum[1];
    end

    always_ff @(posedge aclk) begin
        if (sum_load && prod_valid_reg) begin
            sum_reg <= sum_next;
        end
    end

    firp16_out_stage #(
        .ACC_W (ACC_W)
    ) u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .sum_valid   (sum_valid_reg),
        .sum         (sum_reg),
        .out_valid   (m_tvalid),
        .out_sample  (out_sample),
        .out_clipped (out_clipped)
    );

    assign m_tdata    = out_sample;
    assign m_tuser[0] = out_clipped;

endmodule

/* design/firp16_tap_cell.sv */
// One tap of the direct-form chain: holds one history sample for its neighbour
// and the registered product of its tap sample and coefficient. Depends on firp16_pkg.
module firp16_tap_cell (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  load,
    input  logic                                                  clear,
    input  logic signed [firp16_pkg::SAMPLE_W-1:0]                tap_in,
    input  logic signed [firp16_pkg::COEF_W-1:0]                  coef,
    output logic signed [firp16_pkg::SAMPLE_W-1:0]                tap_out,
    output logic signed [firp16_pkg::SAMPLE_W+firp16_pkg::COEF_W-1:0] prod_out
);
    import firp16_pkg::*;

    localparam int PROD_W = SAMPLE_W + COEF_W;

    logic signed [SAMPLE_W-1:0] tap;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [SAMPLE_W-1:0] tap_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    // restart: this tap sees an empty history
    assign tap       = clear ? '0 : tap_in;
    assign prod_next = tap * coef;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg  <= '0;
            prod_reg <= '0;
        end else if (load) begin
            tap_reg  <= tap;
            prod_reg <= prod_next;
        end
    end

    assign tap_out  = tap_reg;
    assign prod_out = prod_reg;

endmodule

/* design/firp16_out_stage.sv */
// Output register: truncates the exact sum toward zero by 2^15, saturates to
// 16 bits and holds the result transaction. Depends on firp16_pkg.
module firp16_out_stage #(
    parameter int ACC_W = 35
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   advance,
    input  logic                                   sum_valid,
    input  logic signed [ACC_W-1:0]                sum,
    output logic                                   out_valid,
    output logic signed [firp16_pkg::SAMPLE_W-1:0] out_sample,
    output logic                                   out_clipped
);
    import firp16_pkg::*;

    localparam int QW = ACC_W - FRAC_BITS;
    localparam logic signed [QW-1:0] Q_MAX = QW'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [QW-1:0] Q_MIN = -QW'(1 << (SAMPLE_W - 1));
    localparam logic signed [ACC_W-1:0] BIAS = ACC_W'((1 << FRAC_BITS) - 1);

    logic signed [ACC_W-1:0]    biased;
    logic signed [QW-1:0]       quot;
    logic                       over;
    logic                       under;
    logic signed [SAMPLE_W-1:0] sat;

    logic                       valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       clip_reg;

    // negative sums get 2^15-1 added so the arithmetic shift truncates toward zero
    assign biased = sum + (sum[ACC_W-1] ? BIAS : ACC_W'(0));
    assign quot   = QW'(biased >>> FRAC_BITS);
    assign over   = quot > Q_MAX;
    assign under  = quot < Q_MIN;

    always_comb begin
        if (over) begin
            sat = SAMPLE_W'(Q_MAX);
        end else if (under) begin
            sat = SAMPLE_W'(Q_MIN);
        end else begin
            sat = SAMPLE_W'(quot);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && sum_valid) begin
            sample_reg <= sat;
            clip_reg   <= over | under;
        end
    end

    assign out_valid   = valid_reg;
    assign out_sample  = sample_reg;
    assign out_clipped = clip_reg;

endmodule

/* tb/fir_pcm16_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for fir_filter_pcm16_unit: mirrors the coefficient writes, predicts each
// filtered sample from accepted input transactions and compares result transactions.
// Depends on firp16_pkg only.
module fir_pcm16_checker #(
    parameter int TAPS = firp16_pkg::TAPS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] sample_in
    input  logic [0:0]                        s_tuser,   // [0] restart
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [15:0]                       m_tdata,   // [15:0] sample_out
    input  logic [0:0]                        m_tuser,   // [0] clipped
    input  logic                              cfg_we,
    input  logic [firp16_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [firp16_pkg::COEF_W-1:0]     cfg_wdata,
    output int                                mismatches,
    output int                                outstanding
);
    import firp16_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } pcm_result_t;

    logic signed [COEF_W-1:0]   coef_q15 [NUM_COEF];
    logic signed [SAMPLE_W-1:0] delay_line [NUM_COEF-1];  // entry i: sample i+1 back
    pcm_result_t                filtered_q [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Exact product sum, truncated toward zero, then saturated; advances the delay line.
    function automatic pcm_result_t filter_sample(input logic signed [SAMPLE_W-1:0] x,
                                                  input logic restart);
        longint      acc;
        longint      q;
        pcm_result_t r;
        logic signed [SAMPLE_W-1:0] tap;
        if (restart) begin
            foreach (delay_line[i]) delay_line[i] = '0;
        end
        acc = 0;
        for (int n = 0; n < TAPS && n < NUM_COEF; n++) begin
            tap = (n == 0) ? x : delay_line[n-1];
            acc += longint'(coef_q15[n]) * longint'(tap);
        end
        q = (acc >= 0) ? (acc >>> FRAC_BITS) : -((-acc) >>> FRAC_BITS);
        if (q > 32767) begin
            r.sample  = 16'sh7FFF;
            r.clipped = 1'b1;
        end else if (q < -32768) begin
            r.sample  = 16'sh8000;
            r.clipped = 1'b1;
        end else begin
            r.sample  = q[SAMPLE_W-1:0];
            r.clipped = 1'b0;
        end
        for (int i = NUM_COEF - 2; i > 0; i--) delay_line[i] = delay_line[i-1];
        delay_line[0] = x;
        return r;
    endfunction

    always @(posedge aclk) begin
        pcm_result_t want;
        if (!aresetn) begin
            foreach (coef_q15[i]) coef_q15[i] = '0;
            foreach (delay_line[i]) delay_line[i] = '0;
            filtered_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                filtered_q.push_back(filter_sample(s_tdata, s_tuser[0]));
            if (cfg_we)
                coef_q15[cfg_addr] = cfg_wdata;
            if (m_tvalid && m_tready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result sample_out=%0d clipped=%0b",
                                              $signed(m_tdata), m_tuser[0]));
                end else begin
                    want = filtered_q.pop_front();
                    if (m_tdata !== want.sample)
                        report_mismatch($sformatf("sample_out got %0d expected %0d",
                                                  $signed(m_tdata), want.sample));
                    if (m_tuser[0] !== want.clipped)
                        report_mismatch($sformatf("clipped got %0b expected %0b",
                                                  m_tuser[0], want.clipped));
                end
            end
        end
        outstanding = filtered_q.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Bench top for fir_filter_pcm16_unit: clock, reset, coefficient loading and sample
// stimulus with random idling and stalls. Depends on firp16_pkg, DUT, fir_pcm16_checker.
module tb;
    import firp16_pkg::*;

    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 8;
    localparam int CYCLE_LIMIT     = 200000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES    = 8;       // extra wait after the last drain; leave margin

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;    // [15:0] sample_in
    logic [0:0]           s_tuser   = '0;    // [0] restart
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;           // [15:0] sample_out
    logic [0:0]           m_tuser;           // [0] clipped
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [COEF_W-1:0]    cfg_wdata = '0;

    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;
    int          idle_pct    = 0;   // chance per draw that the sender holds off
    int          stall_pct   = 0;   // chance the receiver drops tready
    logic [15:0] coef_set [NUM_COEF];

    fir_filter_pcm16_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    fir_pcm16_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // One input transaction; returns aligned to the edge at which it was taken.
    // tvalid is only written once per step, so back-to-back items keep it high.
    task automatic send_sample(input logic [15:0] sample, input logic restart);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop tvalid and wait for every predicted result to come back; sampled at
    // the falling edge so the checker's update at the rising edge has settled.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        @(posedge aclk);
    endtask

    // Write all eight coefficient registers from coef_set, one per cycle.
    task automatic load_coefs();
        for (int i = 0; i < NUM_COEF; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_IDX_W'(i);
            cfg_wdata <= coef_set[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4, 5:    return 16'($urandom_range(512) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // style 0: full range, 1: extremes, zero and +/-1 only, 2: modest weights as in a real filter
    function automatic logic [15:0] pick_coef(input int style);
        case (style)
            1: begin
                case ($urandom_range(4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    3:       return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            2:       return 16'($urandom_range(8192) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        // Reset held from time zero, then released once for the rest of the run.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, no idling. All weights at the negative extreme: the most
        // negative sample squared clips high, a restart after a full history
        // must wipe it, and -1 times -32768 lands exactly on one LSB.
        foreach (coef_set[i]) coef_set[i] = 16'h8000;
        load_coefs();
        send_sample(16'h8000, 1'b1);
        repeat (3) send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        drain();

        // Tiny weight on the current sample: negative sums must truncate toward
        // zero, not floor; the oldest tap at full positive weight sees the edge
        // of the history window.
        foreach (coef_set[i]) coef_set[i] = 16'h0000;
        coef_set[0] = 16'h0001;
        coef_set[7] = 16'h7FFF;
        load_coefs();
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0001, 1'b0);
        repeat (6) send_sample(16'h8000, 1'b0);
        drain();

        // All weights at the positive extreme: clip high, then clip low after restart.
        foreach (coef_set[i]) coef_set[i] = 16'h7FFF;
        load_coefs();
        send_sample(16'h7FFF, 1'b1);
        repeat (3) send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        repeat (2) send_sample(16'h8000, 1'b0);
        drain();

        // Random phases: each gets fresh weights and one of the four idle and stall modes.
        for (int p = 0; p < NUM_PHASES; p++) begin
            foreach (coef_set[i]) coef_set[i] = pick_coef(p % 3);
            idle_pct  = 0;
            stall_pct = 0;
            load_coefs();
            case (p % 4)
                1: idle_pct = 69;
                2: stall_pct = 69;
                3: begin
                    idle_pct  = 32;
                    stall_pct = 32;
                end
                default: ;
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_sample(pick_sample(), ($urandom_range(15) == 0));
            drain();
        end

        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
